// ----- rtl/ptsb_pkg.sv -----
// Package for the periodic timer slot bank: item types, queue sizing and codes.
`timescale 1ns / 1ps
`default_nettype none
package ptsb_pkg;

	localparam int ID_W     = 16;
	localparam int PERIOD_W = 24;
	localparam int KIND_W   = 2;

	// Command queue between the front and back parts
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// Input kind codes
	typedef enum logic [KIND_W-1:0] {
		KIND_REG    = 2'd0,
		KIND_ENABLE = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_FIRED = 2'd2
	} stat_t;

	// Operation class decided by the front part
	typedef enum logic [1:0] {
		OP_REG  = 2'd0,
		OP_EN   = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP  = 2'd3
	} op_code_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ID_W-1:0]     timer_id;
		logic [PERIOD_W-1:0] period_ticks;
		logic                enable_flag;
	} cmd_t;

	typedef struct packed {
		stat_t           status;
		logic [ID_W-1:0] fired_id;
		logic            last;
	} res_t;

	typedef struct packed {
		op_code_t            op;
		logic [ID_W-1:0]     timer_id;
		logic [PERIOD_W-1:0] period_ticks;
		logic                enable_flag;
	} op_t;

	// Queue head as seen by the back part
	typedef struct packed {
		logic valid;
		op_t  head;
	} q_head_t;

endpackage
`default_nettype wire

// ----- rtl/ptsb_front.sv -----
// Front part: accepts commands, classifies them and queues them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module ptsb_front import ptsb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire cmd_t    cmd,
	output logic         busy,
	output q_head_t      q_out,
	input  wire logic    pop
);

	op_t                entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               push;
	op_t                op_d;

	// Classify the command kind
	always_comb begin
		op_d.timer_id     = cmd.timer_id;
		op_d.period_ticks = cmd.period_ticks;
		op_d.enable_flag  = cmd.enable_flag;
		unique case (kind_t'(cmd.kind))
			KIND_REG:    op_d.op = OP_REG;
			KIND_ENABLE: op_d.op = OP_EN;
			KIND_TICK:   op_d.op = OP_TICK;
			default:     op_d.op = OP_NOP;
		endcase
	end

	assign busy  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign push  = start && !busy;
	assign q_out.valid = (cnt_q != '0);
	assign q_out.head  = entry_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			priority if (push && !pop)
				cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= op_d;
	end

endmodule
`default_nettype wire

// ----- rtl/ptsb_back.sv -----
// Back part: walks the timer slots one per cycle and emits the results.
`timescale 1ns / 1ps
`default_nettype none
module ptsb_back import ptsb_pkg::*; #(
	parameter int TIMER_SLOTS = 10,
	parameter int COUNT_BITS  = 24
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_head_t q_in,
	output logic         pop,
	output logic         result_strobe,
	output res_t         result
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
	localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WALK  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	op_t                  op_q;
	logic                 pend_v_q;
	logic [ID_W-1:0]      pend_id_q;
	logic                 strobe_q;
	res_t                 result_q;

	logic [ID_W-1:0]       ident_q  [TIMER_SLOTS];
	logic [PERIOD_W-1:0]   period_q [TIMER_SLOTS];
	logic [COUNT_BITS-1:0] count_q  [TIMER_SLOTS];
	logic                  en_q     [TIMER_SLOTS];

	logic [ID_W-1:0]       cur_ident;
	logic [PERIOD_W-1:0]   cur_period;
	logic [COUNT_BITS-1:0] cur_count;
	logic                  cur_en;
	logic                  match;
	logic                  fire;
	logic                  at_last;
	logic                  strobe_d;
	res_t                  res_d;

	// Current slot
	assign cur_ident  = ident_q[idx_q];
	assign cur_period = period_q[idx_q];
	assign cur_count  = count_q[idx_q];
	assign cur_en     = en_q[idx_q];
	assign match   = (cur_ident == '0) || (cur_ident == op_q.timer_id);
	assign fire    = (cur_ident != '0) && cur_en &&
		(CMP_W'(cur_period) <= CMP_W'(cur_count));
	assign at_last = (idx_q == LAST_IDX);
	assign pop     = (state_q == S_IDLE) && q_in.valid;

	// Next result
	always_comb begin
		strobe_d = 1'b0;
		res_d    = '{status: STAT_DONE, fired_id: op_q.timer_id, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (q_in.valid && q_in.head.op == OP_NOP) begin
					strobe_d       = 1'b1;
					res_d.fired_id = q_in.head.timer_id;
				end
			end
			S_SCAN: begin
				if (match) begin
					strobe_d = 1'b1;
				end else if (at_last) begin
					strobe_d     = 1'b1;
					res_d.status = (op_q.op == OP_REG) ? STAT_FULL : STAT_DONE;
				end
			end
			S_WALK: begin
				if (fire && pend_v_q) begin
					strobe_d = 1'b1;
					res_d    = '{status: STAT_FIRED, fired_id: pend_id_q, last: 1'b0};
				end
			end
			S_FLUSH: begin
				strobe_d = 1'b1;
				if (pend_v_q)
					res_d = '{status: STAT_FIRED, fired_id: pend_id_q, last: 1'b1};
			end
			default: strobe_d = 1'b0;
		endcase
	end

	// Sequencer and slot control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				ident_q[i] <= '0;
				count_q[i] <= '0;
				en_q[i]    <= 1'b0;
			end
		end else begin
			strobe_q <= strobe_d;
			unique case (state_q)
				S_IDLE: begin
					if (q_in.valid) begin
						idx_q <= '0;
						unique case (q_in.head.op)
							OP_TICK: begin
								pend_v_q <= 1'b0;
								state_q  <= S_WALK;
							end
							OP_REG, OP_EN: state_q <= S_SCAN;
							default:       state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						if (op_q.op == OP_REG) begin
							ident_q[idx_q] <= op_q.timer_id;
							count_q[idx_q] <= '0;
							en_q[idx_q]    <= 1'b1;
						end else begin
							en_q[idx_q]    <= op_q.enable_flag;
						end
						state_q <= S_IDLE;
					end else if (at_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_WALK: begin
					if (fire) begin
						count_q[idx_q] <= '0;
						pend_v_q       <= 1'b1;
					end else if (cur_count != CNT_MAX) begin
						count_q[idx_q] <= cur_count + COUNT_BITS'(1);
					end
					if (at_last)
						state_q <= S_FLUSH;
					else
						idx_q <= idx_q + IDX_W'(1);
				end
				S_FLUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: command, held firing, result, periods
	always_ff @(posedge clk) begin
		result_q <= res_d;
		if (pop)
			op_q <= q_in.head;
		if (state_q == S_WALK && fire)
			pend_id_q <= cur_ident;
		if (state_q == S_SCAN && match && op_q.op == OP_REG)
			period_q[idx_q] <= op_q.period_ticks;
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule
`default_nettype wire

// ----- rtl/periodic_timer_slot_bank.sv -----
// Top level of the periodic timer slot bank: front queue plus slot walker.
//
// Channel   Handshake              Payload
// command   start / busy           cmd    (cmd_t: kind, timer_id, period_ticks, enable_flag)
// result    result_strobe (1 cyc)  result (res_t: status, fired_id, last)
//
// In the back part a register or enable item does a linear slot search, one
// slot per cycle; a tick walks every slot, one slot a cycle, then gives the
// final result; an unused kind is answered straight from idle. A two-entry
// queue lets start be taken while the back part walks. Reset clears the
// identity, count and enable of all slots at once. The receiver cannot stall:
// each result shows for one cycle, one result per cycle at most.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_slot_bank import ptsb_pkg::*; #(
	parameter int TIMER_SLOTS = 10,
	parameter int COUNT_BITS  = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      result_strobe,
	output res_t      result
);

	q_head_t q_head;
	logic    pop;

	ptsb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.q_out  (q_head),
		.pop    (pop)
	);

	ptsb_back #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_in          (q_head),
		.pop           (pop),
		.result_strobe (result_strobe),
		.result        (result)
	);

`ifndef SYNTHESIS
	// The back part only takes from a nonempty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_head.valid)
		else $error("pop from empty queue");

	// An accepted command is in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> q_head.valid)
		else $error("accepted command lost");

	// A full queue stays full until the back part takes an entry
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !pop) |=> busy)
		else $error("queue drained without pop");

	// Out of slots always ends its item
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.status == STAT_FULL) |-> result.last)
		else $error("out-of-slots result without last");
`endif

endmodule
`default_nettype wire
